[hdl/morse_text_encoder_assert.svh]
// ----------------------------------------------------------------------------
// Morse text encoder assertion macros
// Shared macros for the concurrent checks of the encoder's control logic.
// ----------------------------------------------------------------------------
`ifndef MORSE_TEXT_ENCODER_ASSERT_SVH
`define MORSE_TEXT_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mte_pkg.sv]
// ----------------------------------------------------------------------------
// Morse text encoder package
// Beat types, symbol codes and the fixed character code table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mte_pkg;

  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_SPACE = 2'd2;
  localparam logic [1:0] SYM_SLASH = 2'd3;

  localparam int unsigned CODE_MAX = 5;

  typedef struct packed {
    logic       start_of_text;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last_of_run;
  } result_t;

  // A character code: length and symbols left aligned, first symbol in the
  // top bit, a one bit meaning dash.
  typedef struct packed {
    logic [2:0]          len;
    logic [CODE_MAX-1:0] bits;
  } code_t;

  // Work handed from the front part to the back part for one byte.
  typedef struct packed {
    logic  sep;
    logic  lead_space;
    code_t code;
  } job_t;

  function automatic code_t morse_code(input logic [5:0] idx);
    code_t c;
    unique case (idx)
      6'd0:  c = '{3'd2, 5'b01000};
      6'd1:  c = '{3'd4, 5'b10000};
      6'd2:  c = '{3'd4, 5'b10100};
      6'd3:  c = '{3'd3, 5'b10000};
      6'd4:  c = '{3'd1, 5'b00000};
      6'd5:  c = '{3'd4, 5'b00100};
      6'd6:  c = '{3'd3, 5'b11000};
      6'd7:  c = '{3'd4, 5'b00000};
      6'd8:  c = '{3'd2, 5'b00000};
      6'd9:  c = '{3'd4, 5'b01110};
      6'd10: c = '{3'd3, 5'b10100};
      6'd11: c = '{3'd4, 5'b01000};
      6'd12: c = '{3'd2, 5'b11000};
      6'd13: c = '{3'd2, 5'b10000};
      6'd14: c = '{3'd3, 5'b11100};
      6'd15: c = '{3'd4, 5'b01100};
      6'd16: c = '{3'd4, 5'b11010};
      6'd17: c = '{3'd3, 5'b01000};
      6'd18: c = '{3'd3, 5'b00000};
      6'd19: c = '{3'd1, 5'b10000};
      6'd20: c = '{3'd3, 5'b00100};
      6'd21: c = '{3'd4, 5'b00010};
      6'd22: c = '{3'd3, 5'b01100};
      6'd23: c = '{3'd4, 5'b10010};
      6'd24: c = '{3'd4, 5'b10110};
      6'd25: c = '{3'd4, 5'b11000};
      6'd26: c = '{3'd5, 5'b11111};
      6'd27: c = '{3'd5, 5'b01111};
      6'd28: c = '{3'd5, 5'b00111};
      6'd29: c = '{3'd5, 5'b00011};
      6'd30: c = '{3'd5, 5'b00001};
      6'd31: c = '{3'd5, 5'b00000};
      6'd32: c = '{3'd5, 5'b10000};
      6'd33: c = '{3'd5, 5'b11000};
      6'd34: c = '{3'd5, 5'b11100};
      6'd35: c = '{3'd5, 5'b11110};
      default: c = '{3'd0, 5'b00000};
    endcase
    return c;
  endfunction

endpackage

[hdl/mte_front.sv]
// ----------------------------------------------------------------------------
// Morse text encoder front part
// Takes text bytes, tracks word state and makes a job of each byte that emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mte_front
  import mte_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  job_push,
  output job_t  job
);

  logic any_output_yet, any_output_yet_next;
  logic inside_word, inside_word_next;
  logic word_has_letter, word_has_letter_next;

  logic       eff_any, eff_inside, eff_letter;
  logic [7:0] b;
  logic       is_ws, is_upper, is_lower, is_digit, coded;
  logic [7:0] diff;
  logic [5:0] idx;

  always_comb begin
    b          = item.text_byte;
    eff_any    = item.start_of_text ? 1'b0 : any_output_yet;
    eff_inside = item.start_of_text ? 1'b0 : inside_word;
    eff_letter = item.start_of_text ? 1'b0 : word_has_letter;

    is_ws    = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    is_upper = (b >= 8'd65) && (b <= 8'd90);
    is_lower = (b >= 8'd97) && (b <= 8'd122);
    is_digit = (b >= 8'd48) && (b <= 8'd57);
    coded    = is_upper || is_lower || is_digit;

    // Digits follow the 26 letters in the table, so '0' maps to 26.
    if (is_upper) begin
      diff = b - 8'd65;
    end else if (is_lower) begin
      diff = b - 8'd97;
    end else begin
      diff = b - 8'd22;
    end
    idx = diff[5:0];

    job.sep        = !is_ws && !eff_inside && eff_any;
    job.lead_space = coded && eff_inside && eff_letter;
    job.code       = coded ? morse_code(idx) : code_t'('0);
    job_push       = accept && !is_ws && (job.sep || coded);

    if (is_ws) begin
      inside_word_next     = 1'b0;
      word_has_letter_next = eff_letter;
      any_output_yet_next  = eff_any;
    end else begin
      inside_word_next     = 1'b1;
      word_has_letter_next = coded || (eff_inside && eff_letter);
      any_output_yet_next  = eff_any || coded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_output_yet  <= 1'b0;
      inside_word     <= 1'b0;
      word_has_letter <= 1'b0;
    end else if (accept) begin
      any_output_yet  <= any_output_yet_next;
      inside_word     <= inside_word_next;
      word_has_letter <= word_has_letter_next;
    end
  end

endmodule

[hdl/mte_queue.sv]
// ----------------------------------------------------------------------------
// Morse text encoder job queue
// Two-entry queue that decouples the front part from the symbol sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mte_queue
  import mte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  input  logic rd_en,
  output job_t rd_data,
  output logic not_empty,
  output logic full
);

  localparam int unsigned Depth = 2;

  job_t       entries [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rd_data   = entries[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'(Depth));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[hdl/mte_back.sv]
// ----------------------------------------------------------------------------
// Morse text encoder back part
// Sequences a job into symbols, one per cycle unless the output is unpopped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mte_back
  import mte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  job_t    head,
  input  logic    head_valid,
  output logic    head_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  logic                active;
  logic [1:0]          sep_left;
  logic                space_left;
  logic [2:0]          code_left;
  logic [CODE_MAX-1:0] bits;
  logic                out_valid;

  logic [1:0]          cur_sep, nxt_sep;
  logic                cur_space, nxt_space;
  logic [2:0]          cur_len, nxt_len;
  logic [CODE_MAX-1:0] cur_bits, nxt_bits;
  logic                cur_valid, emit, last;
  logic [1:0]          sym;

  assign empty = !out_valid;

  always_comb begin
    // The held job runs first; otherwise the queue head is started directly.
    cur_sep   = active ? sep_left   : (head.sep ? 2'd3 : 2'd0);
    cur_space = active ? space_left : head.lead_space;
    cur_len   = active ? code_left  : head.code.len;
    cur_bits  = active ? bits       : head.code.bits;
    cur_valid = active || head_valid;
    emit      = cur_valid && (!out_valid || pop);
    head_pop  = emit && !active;

    nxt_sep   = cur_sep;
    nxt_space = cur_space;
    nxt_len   = cur_len;
    nxt_bits  = cur_bits;
    if (cur_sep != 2'd0) begin
      sym     = (cur_sep == 2'd2) ? SYM_SLASH : SYM_SPACE;
      nxt_sep = cur_sep - 2'd1;
    end else if (cur_space) begin
      sym       = SYM_SPACE;
      nxt_space = 1'b0;
    end else begin
      sym      = cur_bits[CODE_MAX-1] ? SYM_DASH : SYM_DOT;
      nxt_len  = cur_len - 3'd1;
      nxt_bits = cur_bits << 1;
    end
    last = (nxt_sep == 2'd0) && !nxt_space && (nxt_len == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (emit) begin
      active    <= !last;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sep_left           <= nxt_sep;
      space_left         <= nxt_space;
      code_left          <= nxt_len;
      bits               <= nxt_bits;
      result.symbol      <= sym;
      result.last_of_run <= last;
    end
  end

endmodule

[hdl/morse_text_encoder.sv]
// ----------------------------------------------------------------------------
// Morse text encoder
// Text bytes in, International Morse symbols out, both as queues.
// ----------------------------------------------------------------------------
// Each beat in is one text byte; each beat out is one symbol (dot, dash,
// space or slash) with a flag on the last symbol caused by that byte. The
// front part takes one byte per cycle while the queue is not full and
// tracks word state; a two-entry job queue feeds the back sequencer, which
// sets the sustained rate at one symbol per cycle while its output is free
// or popped. A byte makes as many output beats as it has symbols, from one
// to eight; whitespace and uncoded bytes that emit nothing push no job.
// Assert start_of_text on the first byte of a text to clear word state.
`timescale 1ns / 1ps

module morse_text_encoder
  import mte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic accept;
  logic job_push;
  job_t job;
  job_t head;
  logic head_valid;
  logic head_pop;

  assign accept = push && !full;

  mte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job)
  );

  mte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_data   (job),
    .rd_en     (head_pop),
    .rd_data   (head),
    .not_empty (head_valid),
    .full      (full)
  );

  mte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

`include "morse_text_encoder_assert.svh"

  `MTE_ASSERT_SAME(a_full_has_head, full, head_valid, "queue full but reports no head")
  `MTE_ASSERT_SAME(a_no_push_full, job_push, !full, "job written into a full queue")
  `MTE_ASSERT_SAME(a_ws_no_job, accept && (item.text_byte == 8'd32), !job_push, "space made a job")
  `MTE_ASSERT_NEXT(a_pop_head_out, head_pop, !empty, "job started but no symbol shown")

endmodule
